[rtl/grep_line_field_splitter_defines.svh]
// Assertion macros for the text record field splitter.
`ifndef GREP_LINE_FIELD_SPLITTER_DEFINES_SVH
`define GREP_LINE_FIELD_SPLITTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GLFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GLFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/glfs_pkg.sv]
// Shared constants and types for the text record field splitter.
package glfs_pkg;

  localparam int BYTE_BITS = 8;
  localparam int OUT_BITS  = 32;

  localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/glfs_front.sv]
// Front end: byte classifier and field boundary tracker.
module glfs_front import glfs_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_take,
  input  logic [BYTE_BITS-1:0] text_byte,
  output logic                 rec_push,
  output logic                 rec_bad,
  output logic [POS_BITS-1:0]  rec_start,
  output logic [POS_BITS-1:0]  rec_colon1,
  output logic [POS_BITS-1:0]  rec_colon2,
  output logic [POS_BITS-1:0]  rec_term
);

  typedef enum logic [5:0] {
    MODE_SKIP      = 6'b000001,
    MODE_PATH_OFF1 = 6'b000010,
    MODE_PATH      = 6'b000100,
    MODE_LINE      = 6'b001000,
    MODE_MATCH     = 6'b010000,
    MODE_HALT      = 6'b100000
  } mode_t;

  mode_t               mode, mode_next;
  logic [POS_BITS-1:0] pos, start, colon1, colon2;
  logic [POS_BITS-1:0] start_next, colon1_next, colon2_next;
  logic                is_nl, is_colon, term_hit;
  logic [POS_BITS-1:0] colon1_inc, colon2_inc;

  assign is_nl      = (text_byte == CH_CR) || (text_byte == CH_LF);
  assign is_colon   = (text_byte == CH_COLON);
  assign colon1_inc = colon1 + POS_BITS'(1);
  assign colon2_inc = colon2 + POS_BITS'(1);
  assign term_hit   = (mode == MODE_MATCH) && is_nl;

  always_comb begin
    mode_next   = mode;
    start_next  = start;
    colon1_next = colon1;
    colon2_next = colon2;
    unique case (mode)
      MODE_SKIP: begin
        if (!is_nl) begin
          start_next = pos;
          if (is_colon) begin
            colon1_next = pos;
            mode_next   = MODE_LINE;
          end else begin
            mode_next = MODE_PATH_OFF1;
          end
        end
      end
      // drive letter separator position: any byte passes
      MODE_PATH_OFF1: mode_next = MODE_PATH;
      MODE_PATH: begin
        if (is_colon) begin
          colon1_next = pos;
          mode_next   = MODE_LINE;
        end
      end
      MODE_LINE: begin
        if (is_colon) begin
          colon2_next = pos;
          mode_next   = MODE_MATCH;
        end
      end
      MODE_MATCH: begin
        if (is_nl) begin
          mode_next = rec_bad ? MODE_HALT : MODE_SKIP;
        end
      end
      MODE_HALT: mode_next = MODE_HALT;
      default:   mode_next = MODE_HALT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_SKIP;
      pos    <= '0;
      start  <= '0;
      colon1 <= '0;
      colon2 <= '0;
    end else if (in_take) begin
      mode   <= mode_next;
      pos    <= pos + POS_BITS'(1);
      start  <= start_next;
      colon1 <= colon1_next;
      colon2 <= colon2_next;
    end
  end

  // any empty field marks the line malformed
  assign rec_bad    = (colon1 == start) || (colon2 == colon1_inc) || (pos == colon2_inc);
  assign rec_push   = in_take && term_hit;
  assign rec_start  = start;
  assign rec_colon1 = colon1;
  assign rec_colon2 = colon2;
  assign rec_term   = pos;

endmodule

[rtl/glfs_fifo.sv]
// Short record queue between the front end and the result stage.
module glfs_fifo import glfs_pkg::*; #(
  parameter int WIDTH = 129,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_stat_t       stat
);

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [IDX_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign stat.full  = (count == CNT_BITS'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr + IDX_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr + IDX_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

[rtl/glfs_back.sv]
// Result stage: expands queued records into offsets and holds the output word.
module glfs_back import glfs_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  fifo_stat_t          q_stat,
  input  logic                q_bad,
  input  logic [POS_BITS-1:0] q_start,
  input  logic [POS_BITS-1:0] q_colon1,
  input  logic [POS_BITS-1:0] q_colon2,
  input  logic [POS_BITS-1:0] q_term,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic                status,
  output logic [OUT_BITS-1:0] path_first,
  output logic [OUT_BITS-1:0] path_end,
  output logic [OUT_BITS-1:0] linenum_first,
  output logic [OUT_BITS-1:0] linenum_end,
  output logic [OUT_BITS-1:0] match_first,
  output logic [OUT_BITS-1:0] match_end
);

  logic                out_valid;
  logic                load;
  logic [POS_BITS-1:0] colon1_inc, colon2_inc;

  assign colon1_inc = q_colon1 + POS_BITS'(1);
  assign colon2_inc = q_colon2 + POS_BITS'(1);

  // refill the output word when it is free or being taken this cycle
  assign load  = !q_stat.empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_bad) begin
        status        <= STATUS_BAD;
        path_first    <= '0;
        path_end      <= '0;
        linenum_first <= '0;
        linenum_end   <= '0;
        match_first   <= '0;
        match_end     <= '0;
      end else begin
        status        <= STATUS_OK;
        path_first    <= OUT_BITS'(q_start);
        path_end      <= OUT_BITS'(q_colon1);
        linenum_first <= OUT_BITS'(colon1_inc);
        linenum_end   <= OUT_BITS'(q_colon2);
        match_first   <= OUT_BITS'(colon2_inc);
        match_end     <= OUT_BITS'(q_term);
      end
    end
  end

endmodule

[rtl/grep_line_field_splitter.sv]
// Top level of the text record field splitter.
// Takes one byte of "path:line:match" text per cycle while full is low and reports the six
// field offsets of each record at its CR or LF terminator; a record with an empty field
// yields one malformed status word, after which all input is absorbed without result until
// reset. One byte can be pushed each clock while full is low; a result reaches the output
// through a two-entry record queue and the output register. full rises only when that
// queue is full, i.e. when two records wait behind a result that is not popped. Offsets are
// byte counts modulo 2^POS_BITS, presented on 32-bit ports.
`include "grep_line_field_splitter_defines.svh"

module grep_line_field_splitter import glfs_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [BYTE_BITS-1:0] text_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic                 status,
  output logic [OUT_BITS-1:0]  path_first,
  output logic [OUT_BITS-1:0]  path_end,
  output logic [OUT_BITS-1:0]  linenum_first,
  output logic [OUT_BITS-1:0]  linenum_end,
  output logic [OUT_BITS-1:0]  match_first,
  output logic [OUT_BITS-1:0]  match_end
);

  localparam int REC_BITS = 1 + 4 * POS_BITS;
  localparam int Q_DEPTH  = 2;

  logic                in_take;
  logic                rec_push, rec_bad;
  logic [POS_BITS-1:0] rec_start, rec_colon1, rec_colon2, rec_term;
  logic [REC_BITS-1:0] q_wdata, q_rdata;
  logic                q_pop;
  fifo_stat_t          q_stat;
  logic                q_bad;
  logic [POS_BITS-1:0] q_start, q_colon1, q_colon2, q_term;
  logic                offsets_zero;

  assign full    = q_stat.full;
  assign in_take = push && !full;

  glfs_front #(.POS_BITS(POS_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .text_byte  (text_byte),
    .rec_push   (rec_push),
    .rec_bad    (rec_bad),
    .rec_start  (rec_start),
    .rec_colon1 (rec_colon1),
    .rec_colon2 (rec_colon2),
    .rec_term   (rec_term)
  );

  assign q_wdata = {rec_bad, rec_start, rec_colon1, rec_colon2, rec_term};

  glfs_fifo #(.WIDTH(REC_BITS), .DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  assign {q_bad, q_start, q_colon1, q_colon2, q_term} = q_rdata;

  glfs_back #(.POS_BITS(POS_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_bad         (q_bad),
    .q_start       (q_start),
    .q_colon1      (q_colon1),
    .q_colon2      (q_colon2),
    .q_term        (q_term),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .status        (status),
    .path_first    (path_first),
    .path_end      (path_end),
    .linenum_first (linenum_first),
    .linenum_end   (linenum_end),
    .match_first   (match_first),
    .match_end     (match_end)
  );

  assign offsets_zero = (path_first == '0) && (path_end == '0) &&
                        (linenum_first == '0) && (linenum_end == '0) &&
                        (match_first == '0) && (match_end == '0);

  `GLFS_ASSERT_NOW(a_no_push_full, rec_push, !q_stat.full, "record pushed into full queue")
  `GLFS_ASSERT_NEXT(a_halt_after_bad, rec_push && rec_bad, !rec_push, "record after bad line")
  `GLFS_ASSERT_NOW(a_bad_zero, !empty && status == STATUS_BAD, offsets_zero, "bad word offsets")

endmodule
